// ===== rtl/disk_seek_request_scheduler_defines.svh =====
// Assertion macros for the disk seek request scheduler.
// Used by the checker only; no other dependencies.
`ifndef DISK_SEEK_REQUEST_SCHEDULER_DEFINES_SVH
`define DISK_SEEK_REQUEST_SCHEDULER_DEFINES_SVH

// Same-cycle implication under reset
`define DSSR_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("dssr: same-cycle check failed");

// Next-cycle implication under reset
`define DSSR_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("dssr: next-cycle check failed");

`endif

// ===== rtl/dssr_pkg.sv =====
// Shared codes, constants and the cell control group of the seek scheduler.
// No dependencies.
package dssr_pkg;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_SERVE = 2'd1;
  localparam logic [1:0] MODE_HOME  = 2'd2;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SSTF = 2'd1;
  localparam logic [1:0] POL_SCAN = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam int unsigned CYL_COUNT_RESET = 200;
  localparam logic [31:0] SUM_MAX         = 32'hFFFF_FFFF;

  // Control broadcast to every cell
  typedef struct packed {
    logic fcfs;   // take the first occupied entry
    logic look;   // restrict to entries ahead in the sweep direction
    logic up;     // sweep direction
    logic shift;  // compact the queue over the selected entry
  } cell_ctrl_t;

endpackage

// ===== rtl/dssr_cell.sv =====
// One queue slot: holds a cylinder and forwards the scan token to the next slot.
// Depends on dssr_pkg.
module dssr_cell #(
  parameter int CYLINDER_BITS = 16,
  parameter int IDX_W         = 4,
  parameter int CNT_W         = 5,
  parameter int CELL_INDEX    = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dssr_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CYLINDER_BITS-1:0] head_i,
  input  logic [CNT_W-1:0]         total_i,
  input  logic [IDX_W-1:0]         sel_idx_i,
  input  logic                     wr_en_i,
  input  logic [CYLINDER_BITS-1:0] wr_data_i,
  input  logic [CYLINDER_BITS-1:0] next_cyl_i,
  output logic [CYLINDER_BITS-1:0] cyl_o,
  input  logic                     tok_go_i,
  input  logic                     tok_found_i,
  input  logic [IDX_W-1:0]         tok_idx_i,
  input  logic [CYLINDER_BITS-1:0] tok_cyl_i,
  input  logic [CYLINDER_BITS-1:0] tok_dist_i,
  output logic                     tok_go_o,
  output logic                     tok_found_o,
  output logic [IDX_W-1:0]         tok_idx_o,
  output logic [CYLINDER_BITS-1:0] tok_cyl_o,
  output logic [CYLINDER_BITS-1:0] tok_dist_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

  logic [CYLINDER_BITS-1:0] cyl_q;
  logic                     go_q;
  logic                     found_q, found_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CYLINDER_BITS-1:0] tcyl_q, tcyl_d;
  logic [CYLINDER_BITS-1:0] tdist_q, tdist_d;

  logic                     occupied;
  logic                     at_or_above;
  logic                     at_or_below;
  logic [CYLINDER_BITS-1:0] span;
  logic                     eligible;
  logic                     take;

  always_comb begin
    occupied    = MY_CNT < total_i;
    at_or_above = cyl_q >= head_i;
    at_or_below = cyl_q <= head_i;
    span        = at_or_above ? (cyl_q - head_i) : (head_i - cyl_q);
    eligible    = occupied && (!ctrl_i.look || (ctrl_i.up ? at_or_above : at_or_below));
    // strict compare: the older entry keeps a tie
    take        = eligible && (!tok_found_i || (!ctrl_i.fcfs && (span < tok_dist_i)));
    found_d     = tok_found_i | take;
    idx_d       = take ? MY_IDX : tok_idx_i;
    tcyl_d      = take ? cyl_q : tok_cyl_i;
    tdist_d     = take ? span : tok_dist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= tok_go_i;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    idx_q   <= idx_d;
    tcyl_q  <= tcyl_d;
    tdist_q <= tdist_d;
    if (wr_en_i && (total_i == MY_CNT)) begin
      cyl_q <= wr_data_i;
    end else if (ctrl_i.shift && (sel_idx_i <= MY_IDX)) begin
      cyl_q <= next_cyl_i;
    end
  end

  assign cyl_o       = cyl_q;
  assign tok_go_o    = go_q;
  assign tok_found_o = found_q;
  assign tok_idx_o   = idx_q;
  assign tok_cyl_o   = tcyl_q;
  assign tok_dist_o  = tdist_q;

endmodule

// ===== rtl/disk_seek_request_scheduler.sv =====
// Seek scheduler top: control around the cell chain; depends on dssr_pkg, dssr_cell.
// Add, home, no-op or empty-queue serve: IDLE to DONE; a queued serve runs SCAN first,
// the scan token walking the cell chain one slot a cycle, sweeping again if it reverses.
// DONE registers the result once the output is free. One request at a time: the next is
// taken in the cycle after its result is registered, even while that result waits.
// Async active-low reset: queue empty, head 0, movement 0, sweep up, FCFS, 200.
module disk_seek_request_scheduler #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // mode[1:0], request_cylinder
  input  logic [((2 + CYLINDER_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // target_cylinder, target_valid, request_accepted, head_position,
  // total_movement[31:0], pending_count, sweep_up
  output logic [((2 * CYLINDER_BITS + 35 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                               m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [CYLINDER_BITS:0] cfg_wdata_i
);

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int OUT_RAW = 2 * CYLINDER_BITS + 2 + 32 + CNT_W + 1;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int CB      = CYLINDER_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             start_q, start_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CB-1:0]    head_q, head_d;
  logic [31:0]      sum_q, sum_d;
  logic             up_q, up_d;
  logic [1:0]       policy_q, policy_d;
  logic [CB:0]      count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;
  logic [CB-1:0]    res_target_q, res_target_d;
  logic             res_valid_q, res_valid_d;
  logic             res_acc_q, res_acc_d;

  logic [1:0]       in_mode;
  logic [CB-1:0]    in_req;
  logic             in_accept;
  logic             wr_en;
  logic             shift;
  logic [32:0]      sum_ext;
  dssr_pkg::cell_ctrl_t ctrl;

  logic             tok_go    [QUEUE_DEPTH+1];
  logic             tok_found [QUEUE_DEPTH+1];
  logic [IDX_W-1:0] tok_idx   [QUEUE_DEPTH+1];
  logic [CB-1:0]    tok_cyl   [QUEUE_DEPTH+1];
  logic [CB-1:0]    tok_dist  [QUEUE_DEPTH+1];
  logic [CB-1:0]    cell_cyl  [QUEUE_DEPTH+1];

  assign in_mode   = s_axis_tdata[1:0];
  assign in_req    = s_axis_tdata[CB+1:2];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign tok_go[0]    = start_q;
  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;
  assign tok_cyl[0]   = '0;
  assign tok_dist[0]  = '0;
  assign cell_cyl[QUEUE_DEPTH] = '0;

  always_comb begin
    ctrl.fcfs  = (policy_q != dssr_pkg::POL_SSTF) && (policy_q != dssr_pkg::POL_SCAN);
    ctrl.look  = (policy_q == dssr_pkg::POL_SCAN);
    ctrl.up    = up_q;
    ctrl.shift = shift;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dssr_cell #(
      .CYLINDER_BITS(CB),
      .IDX_W(IDX_W),
      .CNT_W(CNT_W),
      .CELL_INDEX(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .head_i     (head_q),
      .total_i    (total_q),
      .sel_idx_i  (tok_idx[QUEUE_DEPTH]),
      .wr_en_i    (wr_en),
      .wr_data_i  (in_req),
      .next_cyl_i (cell_cyl[i+1]),
      .cyl_o      (cell_cyl[i]),
      .tok_go_i   (tok_go[i]),
      .tok_found_i(tok_found[i]),
      .tok_idx_i  (tok_idx[i]),
      .tok_cyl_i  (tok_cyl[i]),
      .tok_dist_i (tok_dist[i]),
      .tok_go_o   (tok_go[i+1]),
      .tok_found_o(tok_found[i+1]),
      .tok_idx_o  (tok_idx[i+1]),
      .tok_cyl_o  (tok_cyl[i+1]),
      .tok_dist_o (tok_dist[i+1])
    );
  end

  assign sum_ext = {1'b0, sum_q} + 33'(tok_dist[QUEUE_DEPTH]);

  always_comb begin
    state_d      = state_q;
    start_d      = 1'b0;
    total_d      = total_q;
    head_d       = head_q;
    sum_d        = sum_q;
    up_d         = up_q;
    policy_d     = policy_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    res_target_d = res_target_q;
    res_valid_d  = res_valid_q;
    res_acc_d    = res_acc_q;
    wr_en        = 1'b0;
    shift        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_target_d = '0;
          res_valid_d  = 1'b0;
          res_acc_d    = 1'b0;
          state_d      = ST_DONE;
          unique case (in_mode)
            dssr_pkg::MODE_ADD: begin
              if (({1'b0, in_req} < count_q) && (total_q < CNT_W'(QUEUE_DEPTH))) begin
                wr_en     = 1'b1;
                total_d   = total_q + CNT_W'(1);
                res_acc_d = 1'b1;
              end
            end
            dssr_pkg::MODE_SERVE: begin
              if (total_q != '0) begin
                start_d = 1'b1;
                state_d = ST_SCAN;
              end
            end
            dssr_pkg::MODE_HOME: begin
              head_d = '0;
              sum_d  = '0;
              up_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (tok_go[QUEUE_DEPTH]) begin
          if (tok_found[QUEUE_DEPTH]) begin
            shift        = 1'b1;
            total_d      = total_q - CNT_W'(1);
            head_d       = tok_cyl[QUEUE_DEPTH];
            sum_d        = sum_ext[32] ? dssr_pkg::SUM_MAX : sum_ext[31:0];
            res_target_d = tok_cyl[QUEUE_DEPTH];
            res_valid_d  = 1'b1;
            state_d      = ST_DONE;
          end else begin
            // nothing ahead: reverse and sweep again
            up_d    = ~up_q;
            start_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_W'({up_q, total_q, sum_q, head_q,
                                res_acc_q, res_valid_q, res_target_q});
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dssr_pkg::REG_POLICY: begin
          policy_d = cfg_wdata_i[1:0];
          up_d     = 1'b1;
        end
        dssr_pkg::REG_COUNT: count_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      total_q     <= '0;
      head_q      <= '0;
      sum_q       <= '0;
      up_q        <= 1'b1;
      policy_q    <= dssr_pkg::POL_FCFS;
      count_q     <= (CB+1)'(dssr_pkg::CYL_COUNT_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      total_q     <= total_d;
      head_q      <= head_d;
      sum_q       <= sum_d;
      up_q        <= up_d;
      policy_q    <= policy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    res_target_q <= res_target_d;
    res_valid_q  <= res_valid_d;
    res_acc_q    <= res_acc_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/dssr_checker.sv =====
// Port-level checks for the seek scheduler, bound to the top level.
// Depends on disk_seek_request_scheduler_defines.svh.
`include "disk_seek_request_scheduler_defines.svh"

module dssr_checker #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [((2 * CYLINDER_BITS + 35 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                              m_axis_tdata
);

  localparam int CB      = CYLINDER_BITS;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  logic [CB-1:0]    target;
  logic             served;
  logic             queued;
  logic [CB-1:0]    head;
  logic [CNT_W-1:0] pending;
  logic             in_acc;
  logic             out_stall;
  logic             served_out;

  assign target  = m_axis_tdata[CB-1:0];
  assign served  = m_axis_tdata[CB];
  assign queued  = m_axis_tdata[CB+1];
  assign head    = m_axis_tdata[2*CB+1:CB+2];
  assign pending = m_axis_tdata[2*CB+33+CNT_W:2*CB+34];

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign served_out = m_axis_tvalid && served;

  // one request at a time: an accepted request keeps the input closed
  `DSSR_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, !s_axis_tready)
  `DSSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `DSSR_ASSERT_IMPLY(a_served_head, clk_i, rst_ni, served_out, !queued && (head == target))
  `DSSR_ASSERT_IMPLY(a_pending_bound, clk_i, rst_ni, m_axis_tvalid, pending <= CNT_W'(QUEUE_DEPTH))

endmodule

bind disk_seek_request_scheduler dssr_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .CYLINDER_BITS(CYLINDER_BITS)
) u_dssr_checker (.*);
